>>> rtl/lca_pkg.sv
// Shared types, constants and codes of the life cellular automaton step block.
package lca_pkg;

    // Grid geometry; coordinates concatenate into a cell address, so both stay powers of two
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int GRID_DEPTH = 2 * PLANE_SIZE;
    localparam int GRID_AW    = 1 + Y_W + X_W;

    // Configuration port geometry
    localparam int CFG_DIM_W = 10;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WRAP_EDGES  = 2'd2;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RST  = CFG_DIM_W'(MAX_WIDTH);
    localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RST = CFG_DIM_W'(MAX_HEIGHT);

    // Neighbour counting and the B3/S23 rule
    localparam int SUM_W = 4;
    localparam logic [SUM_W-1:0] BIRTH_COUNT   = SUM_W'(3);
    localparam logic [SUM_W-1:0] SURVIVE_COUNT = SUM_W'(2);

    // Row of the window a fetch slot addresses; the last slot only waits for read data
    localparam logic [1:0] ROW_UP   = 2'd0;
    localparam logic [1:0] ROW_MID  = 2'd1;
    localparam logic [1:0] ROW_DOWN = 2'd2;
    localparam logic [1:0] ROW_WAIT = 2'd3;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef struct packed {
        t_func            func;
        logic [X_W-1:0]   cell_x;
        logic [Y_W-1:0]   cell_y;
        logic             cell_value;
    } t_in_item;

    typedef struct packed {
        logic read_value;
        logic op_done;
    } t_out_item;

    // Window control from the sequencer
    typedef struct packed {
        logic       shift;
        logic       cap_en;
        logic [1:0] cap_row;
        logic       cap_live;
    } t_win_ctrl;

endpackage

>>> rtl/lca_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry; hold the data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/lca_window.sv
// Three-by-three neighbourhood window, neighbour count and B3/S23 rule.
module lca_window (
    input  logic               i_clk,
    input  lca_pkg::t_win_ctrl i_ctrl,
    input  logic               i_rd_data,
    output logic               o_next_cell
);

    // Columns left, centre, right; bit index is the row code
    logic [2:0] r_col_l;
    logic [2:0] r_col_c;
    logic [2:0] r_col_r;
    logic [lca_pkg::SUM_W-1:0] sum;

    // Shift the window one column left, capture arriving cells into the right column
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_col_l <= r_col_c;
            r_col_c <= r_col_r;
        end
        if (i_ctrl.cap_en) begin
            r_col_r[i_ctrl.cap_row] <= i_rd_data & i_ctrl.cap_live;
        end
    end

    // Count the eight neighbours
    always_comb begin
        sum = lca_pkg::SUM_W'(r_col_l[lca_pkg::ROW_UP])
            + lca_pkg::SUM_W'(r_col_l[lca_pkg::ROW_MID])
            + lca_pkg::SUM_W'(r_col_l[lca_pkg::ROW_DOWN])
            + lca_pkg::SUM_W'(r_col_c[lca_pkg::ROW_UP])
            + lca_pkg::SUM_W'(r_col_c[lca_pkg::ROW_DOWN])
            + lca_pkg::SUM_W'(r_col_r[lca_pkg::ROW_UP])
            + lca_pkg::SUM_W'(r_col_r[lca_pkg::ROW_MID])
            + lca_pkg::SUM_W'(r_col_r[lca_pkg::ROW_DOWN]);
    end

    // Apply birth on three, survival on two or three
    assign o_next_cell = (sum == lca_pkg::BIRTH_COUNT)
                       | (r_col_c[lca_pkg::ROW_MID] & (sum == lca_pkg::SURVIVE_COUNT));

endmodule

>>> rtl/life_cellular_automaton_step.sv
// Top level of the life cellular automaton step: sequencer, config registers, grid RAM.
// A read, write or unused-code item passes through the result state to a posted result;
// one item is at work at a time. An advance walks the grid row by row over one RAM read
// port: each row preloads the left and centre window columns, then for each cell fetches
// the right column and writes the next state. Reset selects plane 0 and loads the
// register reset values; the grid RAM is not cleared and its cells are undefined until written.
module life_cellular_automaton_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lca_pkg::t_in_item             i_in_item,
    // Result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lca_pkg::t_out_item            o_out_item,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lca_pkg::PADDR_W-1:0]   paddr,
    input  logic [lca_pkg::PDATA_W-1:0]   pwdata,
    output logic [lca_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EVAL  = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        LOAD_LEFT   = 2'd0,
        LOAD_CENTRE = 2'd1,
        LOAD_RIGHT  = 2'd2
    } t_load;

    // Control state
    t_state                            r_state, n_state;
    logic                              r_plane, n_plane;
    logic [lca_pkg::CFG_DIM_W-1:0]     r_grid_width, n_grid_width;
    logic [lca_pkg::CFG_DIM_W-1:0]     r_grid_height, n_grid_height;
    logic                              r_wrap, n_wrap;
    logic                              r_out_valid, n_out_valid;
    logic                              r_cap_en, n_cap_en;

    // Walk and result state
    t_load                             r_load, n_load;
    logic [1:0]                        r_k, n_k;
    logic [lca_pkg::X_W-1:0]           r_x, n_x;
    logic [lca_pkg::Y_W-1:0]           r_y, n_y;
    logic [1:0]                        r_cap_row, n_cap_row;
    logic                              r_cap_live, n_cap_live;
    logic                              r_res_read, n_res_read;
    logic                              r_done, n_done;
    lca_pkg::t_out_item                r_out_item, n_out_item;

    // Combinational helpers
    logic [lca_pkg::CFG_DIM_W-1:0]     w_eff;
    logic [lca_pkg::CFG_DIM_W-1:0]     h_eff;
    logic [lca_pkg::X_W-1:0]           w_last;
    logic [lca_pkg::Y_W-1:0]           h_last;
    logic                              in_acc;
    logic                              in_grid;
    logic                              out_free;
    logic                              cfg_wr;
    logic [1:0]                        cfg_idx;
    logic [lca_pkg::X_W-1:0]           fetch_col;
    logic                              fetch_col_ok;
    logic [lca_pkg::Y_W-1:0]           fetch_row;
    logic                              fetch_row_ok;
    logic                              next_cell;
    lca_pkg::t_win_ctrl                win_ctrl;

    // RAM ports
    logic                              wr_en;
    logic [lca_pkg::GRID_AW-1:0]       wr_addr;
    logic                              wr_data;
    logic                              rd_en;
    logic [lca_pkg::GRID_AW-1:0]       rd_addr;
    logic                              rd_data;

    // Clamp the grid size to the range in use
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = lca_pkg::CFG_DIM_W'(1);
        end else if (r_grid_width > lca_pkg::CFG_DIM_W'(lca_pkg::MAX_WIDTH)) begin
            w_eff = lca_pkg::CFG_DIM_W'(lca_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_grid_width;
        end
        if (r_grid_height == '0) begin
            h_eff = lca_pkg::CFG_DIM_W'(1);
        end else if (r_grid_height > lca_pkg::CFG_DIM_W'(lca_pkg::MAX_HEIGHT)) begin
            h_eff = lca_pkg::CFG_DIM_W'(lca_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_grid_height;
        end
    end

    assign w_last = lca_pkg::X_W'(w_eff - lca_pkg::CFG_DIM_W'(1));
    assign h_last = lca_pkg::Y_W'(h_eff - lca_pkg::CFG_DIM_W'(1));

    // Handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign in_grid    = ({1'b0, i_in_item.cell_x} < w_eff) & ({1'b0, i_in_item.cell_y} < h_eff);

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[lca_pkg::PADDR_W-1:2];

    always_comb begin
        case (cfg_idx)
            lca_pkg::REG_GRID_WIDTH:
                prdata = {{(lca_pkg::PDATA_W-lca_pkg::CFG_DIM_W){1'b0}}, r_grid_width};
            lca_pkg::REG_GRID_HEIGHT:
                prdata = {{(lca_pkg::PDATA_W-lca_pkg::CFG_DIM_W){1'b0}}, r_grid_height};
            lca_pkg::REG_WRAP_EDGES:
                prdata = {{(lca_pkg::PDATA_W-1){1'b0}}, r_wrap};
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        n_grid_width  = r_grid_width;
        n_grid_height = r_grid_height;
        n_wrap        = r_wrap;
        if (cfg_wr) begin
            case (cfg_idx)
                lca_pkg::REG_GRID_WIDTH:  n_grid_width  = pwdata[lca_pkg::CFG_DIM_W-1:0];
                lca_pkg::REG_GRID_HEIGHT: n_grid_height = pwdata[lca_pkg::CFG_DIM_W-1:0];
                lca_pkg::REG_WRAP_EDGES:  n_wrap        = pwdata[0];
                default: ;
            endcase
        end
    end

    // Pick the column to fetch: left and centre of column zero at row start, then right
    always_comb begin
        case (r_load)
            LOAD_LEFT: begin
                fetch_col    = w_last;
                fetch_col_ok = r_wrap;
            end
            LOAD_CENTRE: begin
                fetch_col    = '0;
                fetch_col_ok = 1'b1;
            end
            default: begin
                if (r_x == w_last) begin
                    fetch_col    = '0;
                    fetch_col_ok = r_wrap;
                end else begin
                    fetch_col    = r_x + lca_pkg::X_W'(1);
                    fetch_col_ok = 1'b1;
                end
            end
        endcase
    end

    // Pick the row of the current fetch slot, wrapping or dropping at the edges
    always_comb begin
        case (r_k)
            lca_pkg::ROW_UP: begin
                if (r_y == '0) begin
                    fetch_row    = h_last;
                    fetch_row_ok = r_wrap;
                end else begin
                    fetch_row    = r_y - lca_pkg::Y_W'(1);
                    fetch_row_ok = 1'b1;
                end
            end
            lca_pkg::ROW_DOWN: begin
                if (r_y == h_last) begin
                    fetch_row    = '0;
                    fetch_row_ok = r_wrap;
                end else begin
                    fetch_row    = r_y + lca_pkg::Y_W'(1);
                    fetch_row_ok = 1'b1;
                end
            end
            default: begin
                fetch_row    = r_y;
                fetch_row_ok = 1'b1;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_plane     = r_plane;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_item  = r_out_item;
        n_load      = r_load;
        n_k         = r_k;
        n_x         = r_x;
        n_y         = r_y;
        n_res_read  = r_res_read;
        n_done      = r_done;
        n_cap_en    = 1'b0;
        n_cap_row   = r_k;
        n_cap_live  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = {r_plane, i_in_item.cell_y, i_in_item.cell_x};
        wr_data     = i_in_item.cell_value;
        rd_en       = 1'b0;
        rd_addr     = {r_plane, i_in_item.cell_y, i_in_item.cell_x};
        win_ctrl.shift    = 1'b0;
        win_ctrl.cap_en   = r_cap_en;
        win_ctrl.cap_row  = r_cap_row;
        win_ctrl.cap_live = r_cap_live;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.func)
                        lca_pkg::FUNC_WRITE: begin
                            wr_en      = in_grid;
                            n_res_read = 1'b0;
                            n_done     = 1'b1;
                            n_state    = S_RESP;
                        end
                        lca_pkg::FUNC_READ: begin
                            rd_en      = 1'b1;
                            n_res_read = in_grid;
                            n_done     = 1'b1;
                            n_state    = S_RESP;
                        end
                        lca_pkg::FUNC_ADVANCE: begin
                            n_x     = '0;
                            n_y     = '0;
                            n_load  = LOAD_LEFT;
                            n_k     = lca_pkg::ROW_UP;
                            n_state = S_FETCH;
                        end
                        default: begin
                            n_res_read = 1'b0;
                            n_done     = 1'b0;
                            n_state    = S_RESP;
                        end
                    endcase
                end
            end

            S_FETCH: begin
                if (r_k != lca_pkg::ROW_WAIT) begin
                    // Issue one cell read of the column; tag it for capture next cycle
                    rd_en          = 1'b1;
                    rd_addr        = {r_plane, fetch_row, fetch_col};
                    n_cap_en       = 1'b1;
                    n_cap_row      = r_k;
                    n_cap_live     = fetch_row_ok & fetch_col_ok;
                    n_k            = r_k + 2'd1;
                    win_ctrl.shift = (r_k == lca_pkg::ROW_UP);
                end else begin
                    // Last cell of the column lands this cycle
                    n_k = lca_pkg::ROW_UP;
                    case (r_load)
                        LOAD_LEFT:   n_load  = LOAD_CENTRE;
                        LOAD_CENTRE: n_load  = LOAD_RIGHT;
                        default:     n_state = S_EVAL;
                    endcase
                end
            end

            S_EVAL: begin
                // Write the next state into the other plane and step on
                wr_en   = 1'b1;
                wr_addr = {~r_plane, r_y, r_x};
                wr_data = next_cell;
                if (r_x == w_last) begin
                    n_x    = '0;
                    n_load = LOAD_LEFT;
                    if (r_y == h_last) begin
                        n_plane    = ~r_plane;
                        n_res_read = 1'b0;
                        n_done     = 1'b1;
                        n_state    = S_RESP;
                    end else begin
                        n_y     = r_y + lca_pkg::Y_W'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_x     = r_x + lca_pkg::X_W'(1);
                    n_state = S_FETCH;
                end
            end

            S_RESP: begin
                // Post the result once the output register is free
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.read_value = r_res_read & rd_data;
                    n_out_item.op_done    = r_done;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_plane       <= 1'b0;
            r_grid_width  <= lca_pkg::GRID_WIDTH_RST;
            r_grid_height <= lca_pkg::GRID_HEIGHT_RST;
            r_wrap        <= 1'b1;
            r_out_valid   <= 1'b0;
            r_cap_en      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_plane       <= n_plane;
            r_grid_width  <= n_grid_width;
            r_grid_height <= n_grid_height;
            r_wrap        <= n_wrap;
            r_out_valid   <= n_out_valid;
            r_cap_en      <= n_cap_en;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_load     <= n_load;
        r_k        <= n_k;
        r_x        <= n_x;
        r_y        <= n_y;
        r_cap_row  <= n_cap_row;
        r_cap_live <= n_cap_live;
        r_res_read <= n_res_read;
        r_done     <= n_done;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Both planes in one RAM, plane select as the top address bit
    lca_ram #(
        .WIDTH (1),
        .DEPTH (lca_pkg::GRID_DEPTH)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lca_window u_window (
        .i_clk       (i_clk),
        .i_ctrl      (win_ctrl),
        .i_rd_data   (rd_data),
        .o_next_cell (next_cell)
    );

endmodule
